// File: hdl/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } lkvc_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_in;   // take the input word
    logic capture;   // register search results
    logic commit;    // apply update, load result register
    logic cap_we;    // capacity register write
  } lkvc_cmd_t;

endpackage
`default_nettype wire

// File: hdl/lkvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: accept, search, commit. Owns the handshakes and result valid.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  output lkvc_pkg::lkvc_cmd_t    cmd
);
  import lkvc_pkg::*;

  lkvc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.cap_we  = cfg_valid;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.capture = 1'b1;
        // wait until the result register is free or being drained
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.commit = 1'b1;
        in_ready   = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CMP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// File: hdl/lkvc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_dp
// Entry storage, parallel key compare, LRU/free search, recency update.
// ----------------------------------------------------------------------------
module lkvc_dp #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lkvc_pkg::lkvc_cmd_t           cmd,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0] cfg_capacity_in_use,
  input  wire logic                          in_operation,
  input  wire logic [KEY_BITS-1:0]           in_lookup_key,
  input  wire logic [VALUE_BITS-1:0]         in_store_value,
  output logic                               out_hit,
  output logic [VALUE_BITS-1:0]              out_read_value,
  output logic                               out_evicted,
  output logic [KEY_BITS-1:0]                out_evicted_key
);
  import lkvc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = ((CW > CAP_BITS) ? CW : CAP_BITS) + 1;
  localparam logic [MW-1:0] ENTRIES_M = MW'(ENTRIES);

  logic [CAP_BITS-1:0]   cap_r;
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_in_r;
  logic [VALUE_BITS-1:0] val_in_r;

  logic [ENTRIES-1:0]    valid_r;
  logic [IW-1:0]         rank_r  [ENTRIES];
  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [CW-1:0]         used_r;

  // search results
  logic          hit_found, lru_found, free_found, full, evict, ins;
  logic [IW-1:0] hit_idx, lru_idx, free_idx;
  logic [CW-1:0] used_m1;
  logic [MW-1:0] cap_m;

  logic                  hit_r, evict_r, ins_r;
  logic [IW-1:0]         hit_idx_r, slot_r, tgt_rank_r;
  logic [KEY_BITS-1:0]   evk_r;

  logic                  out_hit_r, out_evicted_r;
  logic [VALUE_BITS-1:0] out_read_value_r;
  logic [KEY_BITS-1:0]   out_evicted_key_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= in_operation;
      key_in_r <= in_lookup_key;
      val_in_r <= in_store_value;
    end
  end

  always_comb begin
    hit_found  = 1'b0;
    lru_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    lru_idx    = '0;
    free_idx   = '0;
    used_m1    = used_r - CW'(1);
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_r[i] && key_r[i] == key_in_r && !hit_found) begin
        hit_found = 1'b1;
        hit_idx   = IW'(i);
      end
      if (valid_r[i] && used_r != '0 && CW'(rank_r[i]) == used_m1 && !lru_found) begin
        lru_found = 1'b1;
        lru_idx   = IW'(i);
      end
      if (!valid_r[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end

    // capacity zero acts as one, above the entry count as the entry count
    cap_m = MW'(cap_r);
    if (cap_m == '0) begin
      cap_m = MW'(1);
    end else if (cap_m > ENTRIES_M) begin
      cap_m = ENTRIES_M;
    end
    full  = MW'(used_r) >= cap_m;
    evict = (op_r == OP_PUT) && !hit_found && full && (used_r != '0) && lru_found;
    ins   = (op_r == OP_PUT) && !hit_found && (evict || free_found);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_r      <= hit_found;
      hit_idx_r  <= hit_idx;
      tgt_rank_r <= rank_r[hit_idx];
      evict_r    <= evict;
      ins_r      <= ins;
      slot_r     <= evict ? lru_idx : free_idx;
      evk_r      <= key_r[lru_idx];
    end
  end

  // recency, valid bits, fill count, capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      cap_r   <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cmd.cap_we) begin
        cap_r <= cfg_capacity_in_use;
      end
      if (cmd.commit) begin
        if (hit_r) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && rank_r[i] < tgt_rank_r) begin
              rank_r[i] <= rank_r[i] + IW'(1);
            end
          end
          rank_r[hit_idx_r] <= '0;
        end else if (ins_r) begin
          // evicted slot is reused at once, everyone else ages by one
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && IW'(i) != slot_r) begin
              rank_r[i] <= rank_r[i] + IW'(1);
            end
          end
          rank_r[slot_r]  <= '0;
          valid_r[slot_r] <= 1'b1;
          if (!evict_r) begin
            used_r <= used_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && ins_r) begin
      key_r[slot_r] <= key_in_r;
    end
  end

  // value memory, read into the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_r == OP_PUT && (hit_r || ins_r)) begin
        val_mem[hit_r ? hit_idx_r : slot_r] <= val_in_r;
      end
      if (op_r == OP_PUT) begin
        out_read_value_r <= '0;
      end else if (hit_r) begin
        out_read_value_r <= val_mem[hit_idx_r];
      end else begin
        out_read_value_r <= '1;
      end
      out_hit_r         <= hit_r;
      out_evicted_r     <= evict_r;
      out_evicted_key_r <= evict_r ? evk_r : '0;
    end
  end

  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule
`default_nettype wire

// File: hdl/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_capacity_in_use
//  in      | in        | in_valid/in_ready    | in_operation, in_lookup_key, in_store_value
//  out     | out       | out_valid/out_ready  | out_hit, out_read_value, out_evicted,
//          |           |                      | out_evicted_key
//
//  Each word passes a compare state (parallel key compare and LRU/free search)
//  and an update state (recency update, entry write and result load). A new
//  word is taken in the update state, so the block holds one word at a time.
//  The result register is loaded at the commit in the update state.
//  Reset clears valid bits, ranks and fill count at once; no clearing pass.
//  A result left waiting holds the next word in its compare state.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0] cfg_capacity_in_use,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic signed [KEY_BITS-1:0]    in_lookup_key,
  input  wire logic signed [VALUE_BITS-1:0]  in_store_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic signed [VALUE_BITS-1:0]       out_read_value,
  output logic                               out_evicted,
  output logic signed [KEY_BITS-1:0]         out_evicted_key
);
  import lkvc_pkg::*;

  lkvc_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  lkvc_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .in_operation        (in_operation),
    .in_lookup_key       (in_lookup_key),
    .in_store_value      (in_store_value),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value),
    .out_evicted         (out_evicted),
    .out_evicted_key     (out_evicted_key)
  );

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  // after taking a word the block searches before taking another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken during search");

  // a new result only comes from a commit
  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid without commit");

endmodule
`default_nettype wire

// File: verif/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_tb
// Self-checking bench for the LRU key-value cache. A queue-fed driver pushes
// get/put words through the valid/ready input channel while a clocked monitor
// predicts each response with a behavioral LRU model and compares every field.
// Capacity is rewritten between drained phases, including 0 and out-of-range
// values, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb;
  import lkvc_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 13;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] val;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] rd;
    logic        ev;
    logic [31:0] evk;
  } resp_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] cfg_capacity_in_use = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_operation = OP_GET;
  logic signed [31:0]  in_lookup_key = '0;
  logic signed [31:0]  in_store_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic signed [31:0]  out_read_value;
  logic                out_evicted;
  logic signed [31:0]  out_evicted_key;

  lru_key_value_cache_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_lookup_key       (in_lookup_key),
    .in_store_value      (in_store_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value),
    .out_evicted         (out_evicted),
    .out_evicted_key     (out_evicted_key)
  );

  always #6 clk = ~clk;

  // shadow copy of the cache
  logic [31:0]         m_key   [ENTRIES];
  logic [31:0]         m_val   [ENTRIES];
  bit                  m_valid [ENTRIES];
  int                  m_rank  [ENTRIES];
  int                  m_used;
  logic [CAP_BITS-1:0] cap_reg;

  req_t  req_queue [$];
  resp_t resp_due  [$];

  bit    idle_on = 1'b1;
  bit    in_accepted = 1'b0;
  int    send_gap = 0;
  int    stall_left = 0;
  int    err_count = 0;
  int    n_checked = 0;
  int    n_hits = 0;
  int    n_evict = 0;
  int    cycles = 0;

  logic [CAP_BITS-1:0] cap_plan [N_PHASES] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd17, 5'd2, 5'd5, 5'd12, 5'd16, 5'd4, 5'd1
  };

  function automatic resp_t lru_access(logic op, logic [31:0] key, logic [31:0] val);
    resp_t r;
    int    idx;
    int    slot;
    int    cap;
    int    old_rank;
    r    = '0;
    idx  = -1;
    slot = -1;
    cap  = cap_reg;
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    for (int i = 0; i < ENTRIES; i++)
      if (idx < 0 && m_valid[i] && m_key[i] == key) idx = i;
    if (idx >= 0) begin
      r.hit = 1'b1;
      old_rank = m_rank[idx];
      for (int i = 0; i < ENTRIES; i++)
        if (m_valid[i] && m_rank[i] < old_rank) m_rank[i]++;
      m_rank[idx] = 0;
      if (op == OP_PUT) m_val[idx] = val;
      else r.rd = m_val[idx];
    end else if (op == OP_GET) begin
      r.rd = '1;
    end else begin
      // full (or over-full after a capacity drop): the oldest entry goes
      if (m_used >= cap && m_used > 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (m_valid[i] && m_rank[i] == m_used - 1) slot = i;
        if (slot >= 0) begin
          r.ev = 1'b1;
          r.evk = m_key[slot];
          m_valid[slot] = 1'b0;
          m_used--;
        end
      end
      if (slot < 0)
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!m_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (m_valid[i]) m_rank[i]++;
        m_valid[slot] = 1'b1;
        m_key[slot]   = key;
        m_val[slot]   = val;
        m_rank[slot]  = 0;
        m_used++;
      end
    end
    return r;
  endfunction

  function automatic void push_req(logic op, logic [31:0] key, logic [31:0] val);
    req_t r;
    r.op  = op;
    r.key = key;
    r.val = val;
    req_queue.push_back(r);
  endfunction

  // Random words over a key pool sized near the capacity so that hits,
  // updates and evictions all show up; a tenth of the keys are wild.
  task automatic queue_random(int n, logic [CAP_BITS-1:0] cap);
    logic [31:0] pool [$];
    int          cap_eff;
    int          psize;
    cap_eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
    psize = cap_eff + $urandom_range(1, cap_eff + 4);
    for (int i = 0; i < psize; i++)
      case ($urandom_range(0, 11))
        0:       pool.push_back(32'h8000_0000);
        1:       pool.push_back(32'h7fff_ffff);
        2:       pool.push_back(32'h0000_0000);
        3:       pool.push_back(32'hffff_ffff);
        default: pool.push_back($urandom);
      endcase
    for (int i = 0; i < n; i++)
      push_req($urandom_range(0, 1) ? OP_PUT : OP_GET,
               ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, psize - 1)],
               $urandom);
  endtask

  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || resp_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_BITS-1:0] cap);
    @(negedge clk);
    cfg_capacity_in_use <= cap;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver
  always @(negedge clk) begin
    req_t w;
    if (!in_valid || in_accepted) begin
      if (idle_on && send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else if (req_queue.size() != 0) begin
        w = req_queue.pop_front();
        in_valid       <= 1'b1;
        in_operation   <= w.op;
        in_lookup_key  <= w.key;
        in_store_value <= w.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_accepted = 1'b0;
  end

  // result back-pressure
  always @(negedge clk) begin
    if (idle_on && stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check result words, track config, predict accepted words
  always @(posedge clk) begin
    resp_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (resp_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result word with nothing outstanding: hit=%0d rd=%h ev=%0d evk=%h",
                     $realtime, out_hit, out_read_value, out_evicted, out_evicted_key);
        end else begin
          e = resp_due.pop_front();
          n_checked++;
          if (e.hit) n_hits++;
          if (e.ev) n_evict++;
          if (out_hit !== e.hit || out_read_value !== e.rd ||
              out_evicted !== e.ev || out_evicted_key !== e.evk) begin
            err_count++;
            if (err_count <= 10) begin
              $write("%0t: mismatch on word %0d: exp hit=%0d rd=%h ev=%0d evk=%h,",
                     $realtime, n_checked, e.hit, e.rd, e.ev, e.evk);
              $display(" got hit=%0d rd=%h ev=%0d evk=%h",
                       out_hit, out_read_value, out_evicted, out_evicted_key);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_capacity_in_use;
      if (in_valid && in_ready) begin
        resp_due.push_back(lru_access(in_operation, in_lookup_key, in_store_value));
        in_accepted = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, resp_due.size());
      $display("lru_key_value_cache_top regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      m_key[i]   = '0;
      m_val[i]   = '0;
      m_valid[i] = 1'b0;
      m_rank[i]  = 0;
    end
    m_used  = 0;
    cap_reg = CAP_RESET;
    cap_plan[9] = CAP_BITS'($urandom_range(0, 31));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes at reset capacity: empty miss, min/max keys and values, update
    push_req(OP_GET, 32'h0000_0000, 32'h1234_5678);
    push_req(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    push_req(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    push_req(OP_PUT, 32'h0000_0000, 32'hffff_ffff);
    push_req(OP_PUT, 32'hffff_ffff, 32'h0000_0000);
    push_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
    push_req(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    push_req(OP_GET, 32'hffff_ffff, 32'h0000_0000);
    push_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
    push_req(OP_PUT, 32'h8000_0000, 32'h0000_0005);
    push_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
    push_req(OP_GET, 32'h0000_0001, 32'h0000_0000);
    wait_drained();

    // capacity below the fill count, then plain eviction order at capacity 2
    set_capacity(5'd2);
    push_req(OP_PUT, 32'd10, 32'd100);
    push_req(OP_PUT, 32'd20, 32'd200);
    push_req(OP_PUT, 32'd30, 32'd300);
    push_req(OP_GET, 32'd20, 32'd0);
    push_req(OP_PUT, 32'd40, 32'd400);
    push_req(OP_GET, 32'd10, 32'd0);
    push_req(OP_GET, 32'd30, 32'd0);
    push_req(OP_PUT, 32'd40, 32'd1);
    push_req(OP_GET, 32'd40, 32'd0);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      idle_on = (p < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
      set_capacity(cap_plan[p]);
      queue_random(100, cap_plan[p]);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("%0d result words checked across %0d capacity settings (0 and 31 included)",
             n_checked, N_PHASES + 1);
    $display("%0d hits, %0d evictions, %0d mismatches", n_hits, n_evict, err_count);
    if (err_count == 0)
      $display("lru_key_value_cache_top regression: pass");
    else
      $display("lru_key_value_cache_top regression: fail");
    $finish;
  end

endmodule
